// ===== src/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned HEAD_W    = SLOT_W + 1;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned MAX_SLOTS = 1 << SLOT_W;

    localparam logic [HEAD_W-1:0] NO_SLOT  = HEAD_W'(MAX_SLOTS);
    localparam logic [HEAD_W-1:0] CAP_MIN  = HEAD_W'(1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] granted_slot;
        logic [HEAD_W-1:0] available;
        logic [CNT_W-1:0]  allocate_total;
        logic [CNT_W-1:0]  free_total;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [HEAD_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } ram_ctrl_t;

endpackage

// ===== src/fsa_link_ram.sv =====
// ----------------------------------------------------------------------------
// fsa_link_ram
// Next-link store of the freed chain: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module fsa_link_ram
    import fsa_pkg::*;
(
    input  logic              clk,
    input  ram_ctrl_t         ctrl,
    output logic [HEAD_W-1:0] rd_data
);

    logic [HEAD_W-1:0] mem [MAX_SLOTS];
    logic [HEAD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Flow: a taken request is executed in S_REQ and its result is registered;
//   an allocate served from the freed chain first reads the link memory and
//   completes in S_WAIT. A new request is taken as the current one completes.
// Reset: control and counters cleared, capacity 256, freed chain empty;
//   the link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator
    import fsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [HEAD_W-1:0] cfg_wr_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [SLOT_W-1:0] slot_index,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [SLOT_W-1:0] granted_slot,
    output logic [HEAD_W-1:0] available,
    output logic [CNT_W-1:0]  allocate_total,
    output logic [CNT_W-1:0]  free_total
);

    typedef enum logic [1:0] {
        S_EMPTY,
        S_REQ,
        S_WAIT
    } state_t;

    state_t            state_reg;
    logic              mode_reg;
    logic [SLOT_W-1:0] idx_reg;

    logic [HEAD_W-1:0] capacity_reg;
    logic [HEAD_W-1:0] head_reg,     head_next;
    logic [HEAD_W-1:0] frontier_reg, frontier_next;
    logic [HEAD_W-1:0] count_reg,    count_next;
    logic [CNT_W-1:0]  alloc_reg,    alloc_next;
    logic [CNT_W-1:0]  release_reg,  release_next;

    result_t           out_reg, res_next;
    logic              out_valid_reg;

    ram_ctrl_t         ram_ctrl;
    logic [HEAD_W-1:0] link_rd;

    logic              out_free;
    logic              head_valid;
    logic              issue_read;
    logic              done;
    logic              take;
    logic [HEAD_W-1:0] cap_clamped;

    fsa_link_ram u_link_ram
    (
        .clk     (clk),
        .ctrl    (ram_ctrl),
        .rd_data (link_rd)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign head_valid = !head_reg[HEAD_W-1];
    assign issue_read = (state_reg == S_REQ) && (mode_reg == MODE_ALLOC) && head_valid;
    assign done       = out_free && (((state_reg == S_REQ) && !issue_read)
                                     || (state_reg == S_WAIT));
    assign in_stall   = !((state_reg == S_EMPTY) || done);
    assign take       = in_valid && !in_stall;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_clamped = CAP_MIN;
        end
        else if (cfg_wr_data > NO_SLOT)
        begin
            cap_clamped = NO_SLOT;
        end
        else
        begin
            cap_clamped = cfg_wr_data;
        end
    end

    // request execution
    always_comb
    begin
        head_next     = head_reg;
        frontier_next = frontier_reg;
        count_next    = count_reg;
        alloc_next    = alloc_reg;
        release_next  = release_reg;
        res_next.ok           = 1'b0;
        res_next.granted_slot = '0;

        ram_ctrl.wr_en   = 1'b0;
        ram_ctrl.wr_addr = idx_reg;
        ram_ctrl.wr_data = head_reg;
        ram_ctrl.rd_en   = issue_read;
        ram_ctrl.rd_addr = head_reg[SLOT_W-1:0];

        if (state_reg == S_WAIT)
        begin
            res_next.ok           = 1'b1;
            res_next.granted_slot = head_reg[SLOT_W-1:0];
            head_next             = (link_rd > NO_SLOT) ? NO_SLOT : link_rd;
        end
        else if (mode_reg == MODE_ALLOC)
        begin
            if (frontier_reg < capacity_reg)
            begin
                res_next.ok           = 1'b1;
                res_next.granted_slot = frontier_reg[SLOT_W-1:0];
                frontier_next         = frontier_reg + HEAD_W'(1);
            end
        end
        else
        begin
            if ({1'b0, idx_reg} < capacity_reg)
            begin
                res_next.ok    = 1'b1;
                ram_ctrl.wr_en = done;
                head_next      = {1'b0, idx_reg};
                if (count_reg < capacity_reg)
                begin
                    count_next = count_reg + HEAD_W'(1);
                end
                release_next = release_reg + CNT_W'(1);
            end
        end

        if (res_next.ok && ((state_reg == S_WAIT) || (mode_reg == MODE_ALLOC)))
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - HEAD_W'(1);
            end
            alloc_next = alloc_reg + CNT_W'(1);
        end

        res_next.available      = count_next;
        res_next.allocate_total = alloc_next;
        res_next.free_total     = release_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EMPTY;
            out_valid_reg <= 1'b0;
            capacity_reg  <= NO_SLOT;
            head_reg      <= NO_SLOT;
            frontier_reg  <= '0;
            count_reg     <= NO_SLOT;
            alloc_reg     <= '0;
            release_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_EMPTY:
                begin
                    if (take)
                    begin
                        state_reg <= S_REQ;
                    end
                end
                S_REQ:
                begin
                    if (issue_read)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else if (done && !take)
                    begin
                        state_reg <= S_EMPTY;
                    end
                end
                S_WAIT:
                begin
                    if (done)
                    begin
                        state_reg <= take ? S_REQ : S_EMPTY;
                    end
                end
                default:
                begin
                    state_reg <= S_EMPTY;
                end
            endcase

            if (done)
            begin
                out_valid_reg <= 1'b1;
                head_reg      <= head_next;
                frontier_reg  <= frontier_next;
                count_reg     <= count_next;
                alloc_reg     <= alloc_next;
                release_reg   <= release_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // capacity write starts a fresh pool with every slot free; totals kept
            if (cfg_wr_en)
            begin
                capacity_reg <= cap_clamped;
                head_reg     <= NO_SLOT;
                frontier_reg <= '0;
                count_reg    <= cap_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg <= mode;
            idx_reg  <= slot_index;
        end
        if (done)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = out_reg.ok;
    assign granted_slot   = out_reg.granted_slot;
    assign available      = out_reg.available;
    assign allocate_total = out_reg.allocate_total;
    assign free_total     = out_reg.free_total;

endmodule

// ===== tb/slot_pool_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_monitor
// Watches the request, result and capacity ports of the free-list allocator.
// Keeps its own copy of the pool (link chain, fresh frontier, free count and
// totals), works out the result of every accepted request and compares each
// accepted result, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module slot_pool_monitor
    import fsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [HEAD_W-1:0] cfg_wr_data,

    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              mode,
    input  logic [SLOT_W-1:0] slot_index,

    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              ok,
    input  logic [SLOT_W-1:0] granted_slot,
    input  logic [HEAD_W-1:0] available,
    input  logic [CNT_W-1:0]  allocate_total,
    input  logic [CNT_W-1:0]  free_total,

    output int                mismatches,
    output int                outstanding
);

    logic [HEAD_W-1:0] next_link [MAX_SLOTS];
    logic [HEAD_W-1:0] chain_head;
    logic [HEAD_W-1:0] frontier;
    logic [HEAD_W-1:0] free_slots;
    logic [HEAD_W-1:0] pool_size;
    logic [CNT_W-1:0]  grants;
    logic [CNT_W-1:0]  releases;
    result_t           awaited_results [$];

    function automatic result_t serve_request(input logic req_mode,
                                              input logic [SLOT_W-1:0] idx);
        result_t r;
        r = '0;
        if (req_mode == MODE_ALLOC)
        begin
            if (chain_head != NO_SLOT)
            begin
                r.granted_slot = chain_head[SLOT_W-1:0];
                chain_head     = next_link[chain_head[SLOT_W-1:0]];
                r.ok           = 1'b1;
            end
            else if (frontier < pool_size)
            begin
                r.granted_slot = frontier[SLOT_W-1:0];
                frontier       = frontier + HEAD_W'(1);
                r.ok           = 1'b1;
            end
            if (r.ok)
            begin
                if (free_slots != '0)
                    free_slots = free_slots - HEAD_W'(1);
                grants = grants + CNT_W'(1);
            end
        end
        else if ({1'b0, idx} < pool_size)
        begin
            // double frees are pushed again; the free count saturates
            next_link[idx] = chain_head;
            chain_head     = {1'b0, idx};
            if (free_slots < pool_size)
                free_slots = free_slots + HEAD_W'(1);
            releases = releases + CNT_W'(1);
            r.ok     = 1'b1;
        end
        r.available      = free_slots;
        r.allocate_total = grants;
        r.free_total     = releases;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pool_size  = HEAD_W'(MAX_SLOTS);
            chain_head = NO_SLOT;
            frontier   = '0;
            free_slots = HEAD_W'(MAX_SLOTS);
            grants     = '0;
            releases   = '0;
            awaited_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_wr_data == '0)
                    pool_size = CAP_MIN;
                else if (cfg_wr_data > HEAD_W'(MAX_SLOTS))
                    pool_size = HEAD_W'(MAX_SLOTS);
                else
                    pool_size = cfg_wr_data;
                chain_head = NO_SLOT;
                frontier   = '0;
                free_slots = pool_size;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request awaiting one", $time);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("ok", CNT_W'(want.ok), CNT_W'(ok));
                    check_field("granted_slot", CNT_W'(want.granted_slot),
                                CNT_W'(granted_slot));
                    check_field("available", CNT_W'(want.available), CNT_W'(available));
                    check_field("allocate_total", want.allocate_total, allocate_total);
                    check_field("free_total", want.free_total, free_total);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(serve_request(mode, slot_index));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Request stimulus for the free-list allocator: a directed opening run over
// the pool edge cases, then phases of random allocate/free traffic at a range
// of capacities, with random request gaps in some phases and result stalls.
// Results are checked by slot_pool_monitor; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import fsa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 10;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [HEAD_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [SLOT_W-1:0] slot_index;
    logic              out_valid;
    logic              out_stall;
    logic              ok;
    logic [SLOT_W-1:0] granted_slot;
    logic [HEAD_W-1:0] available;
    logic [CNT_W-1:0]  allocate_total;
    logic [CNT_W-1:0]  free_total;

    int mismatches;
    int outstanding;

    logic              sent_modes [$];
    logic [SLOT_W-1:0] live_slots [$];
    int                pool_cap;
    bit                hold_request;

    int phase_cap   [PHASES] = '{0, 2, 3, 17, 511, 300, 128, 1, 64, 256};
    int phase_items [PHASES] = '{60, 80, 80, 150, 360, 150, 130, 50, 120, 120};
    int phase_alloc [PHASES] = '{50, 55, 60, 65, 98, 70, 60, 50, 75, 60};

    fixed_slot_free_list_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .granted_slot   (granted_slot),
        .available      (available),
        .allocate_total (allocate_total),
        .free_total     (free_total)
    );

    slot_pool_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .granted_slot   (granted_slot),
        .available      (available),
        .allocate_total (allocate_total),
        .free_total     (free_total),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input logic req_mode, input logic [SLOT_W-1:0] idx);
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= req_mode;
        slot_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        sent_modes.push_back(req_mode);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid   <= 1'b0;
            slot_index <= SLOT_W'($urandom_range(0, 255));
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_capacity(input int value);
        idle_cycles(1);
        drain();
        repeat (3) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= HEAD_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        live_slots.delete();
        pool_cap = (value == 0) ? 1 : ((value > MAX_SLOTS) ? MAX_SLOTS : value);
    endtask

    task automatic random_request(input int alloc_pct, input bit steady);
        logic              req_mode;
        logic [SLOT_W-1:0] idx;
        int                r;
        int                k;
        idx = SLOT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < alloc_pct)
            req_mode = MODE_ALLOC;
        else
        begin
            req_mode = MODE_FREE;
            r = $urandom_range(0, 99);
            if (live_slots.size() > 0 && r < 85)
            begin
                k   = $urandom_range(0, live_slots.size() - 1);
                idx = live_slots[k];
                live_slots.delete(k);
            end
            else if (r < 92)
                idx = SLOT_W'($urandom_range(0, pool_cap - 1));
        end
        send_request(req_mode, idx);
        if (!steady)
            idle_cycles(idle_length());
    endtask

    // grants seen on the result side feed well-formed frees
    always @(posedge clk)
    begin
        logic m;
        if (rst_n && out_valid && !out_stall && sent_modes.size() > 0)
        begin
            m = sent_modes.pop_front();
            if (m == MODE_ALLOC && ok)
                live_slots.push_back(granted_slot);
        end
    end

    initial
    begin : receiver
        int seg_left;
        int stall_pct;
        int run;
        bit held;
        out_stall = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        held      = 1'b0;
        @(negedge clk);
        forever
        begin
            if (seg_left <= 0)
            begin
                seg_left = $urandom_range(20, 150);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            if (hold_request && !held)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                held = 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (run) @(negedge clk);
                seg_left -= run;
            end
            else
            begin
                out_stall <= 1'b0;
                @(negedge clk);
                seg_left--;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int  pct;
        bit  steady;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        mode         = MODE_ALLOC;
        slot_index   = '0;
        hold_request = 1'b0;
        pool_cap     = MAX_SLOTS;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full pool at reset capacity: free into a full pool, chain before fresh
        send_request(MODE_FREE,  8'hFF);
        send_request(MODE_ALLOC, 8'hFF);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE,  8'h00);
        send_request(MODE_FREE,  8'h01);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE,  8'hAA);
        send_request(MODE_FREE,  8'h55);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);

        // zero capacity is taken as one slot: empty pool, out of range, double free
        write_capacity(0);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE,  8'h01);
        send_request(MODE_FREE,  8'hFF);
        send_request(MODE_FREE,  8'h00);
        send_request(MODE_FREE,  8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            steady = (p % 3 == 0);
            if (p == 3)
                hold_request = 1'b1;
            for (int i = 0; i < phase_items[p]; i++)
            begin
                pct = (i < (phase_items[p] * 3) / 4) ? phase_alloc[p] : 100 - phase_alloc[p];
                if (p == 5 && i == phase_items[p] / 2)
                begin
                    idle_cycles(1);
                    drain();
                end
                random_request(pct, steady);
            end
        end

        idle_cycles(1);
        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/fsa_pkg.sv
src/fsa_link_ram.sv
src/fixed_slot_free_list_allocator.sv
tb/slot_pool_monitor.sv
tb/tb.sv
